### sv/bpfa_pkg.sv
// Shared constants and types of the bitmap page-frame allocator.
package bpfa_pkg;

    localparam int MAP_WORDS    = 4096;
    localparam int WORD_AW      = $clog2(MAP_WORDS);
    localparam int BLOCK_SHIFT  = 12;
    localparam int ADDR_W       = 29;
    localparam int BYTES_W      = 30;
    localparam int BLK_W        = ADDR_W - BLOCK_SHIFT;
    localparam int TOTAL_BLOCKS = MAP_WORDS * 32;
    localparam int CNT_W        = $clog2(TOTAL_BLOCKS + 1);
    localparam int N_W          = BYTES_W - BLOCK_SHIFT + 1;
    localparam int MAX_W0       = (N_W > BLK_W) ? N_W : BLK_W;
    localparam int END_W        = ((MAX_W0 > CNT_W) ? MAX_W0 : CNT_W) + 1;
    localparam int RUN_BLOCKS   = 32'h0020_0000 >> BLOCK_SHIFT;

    localparam logic [31:0] FULL_WORD = 32'hffff_ffff;

    typedef enum logic [2:0] {
        MD_ALLOC  = 3'd0,
        MD_FREE   = 3'd1,
        MD_USED   = 3'd2,
        MD_UNUSED = 3'd3,
        MD_RUN    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_FREE0 = 2'd2
    } t_status;

    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [31:0]        wr_data;
    } t_map_req;

endpackage

### sv/bpfa_map.sv
// Usage bitmap memory with the all-used fill sweep after reset.
module bpfa_map
    import bpfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_map_req    i_req,
    output logic [31:0] o_rd_data,
    output logic        o_ready
);

    logic [31:0]        mem [MAP_WORDS];
    logic               r_fill_busy;
    logic [WORD_AW-1:0] r_fill_addr;
    logic               wr_en;
    logic [WORD_AW-1:0] wr_addr;
    logic [31:0]        wr_data;

    assign wr_en   = r_fill_busy | i_req.wr_en;
    assign wr_addr = r_fill_busy ? r_fill_addr : i_req.wr_addr;
    assign wr_data = r_fill_busy ? FULL_WORD : i_req.wr_data;
    assign o_ready = ~r_fill_busy;

    // sweep every word to all ones, one word a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_busy <= 1'b1;
            r_fill_addr <= '0;
        end else if (r_fill_busy) begin
            r_fill_addr <= r_fill_addr + WORD_AW'(1);
            if (r_fill_addr == WORD_AW'(MAP_WORDS - 1)) begin
                r_fill_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_data <= mem[i_req.rd_addr];
        end
    end

endmodule

### sv/bitmap_page_frame_allocator.sv
// Top level of the bitmap page-frame allocator: command sequencer and result register.
// Sequence, accept to next accept: allocate reads W bitmap words from the hint (wrapping to word 1),
//   at most MAP_WORDS - 1, then writes the found word back on a hit or reports out of memory;
//   free, region and run items read and write back each of the K words touched; free of block 0,
//   blocks past the map and unknown modes go straight to the result; the result may wait on tready.
// Throughput: one word read per cycle while scanning; each region word is read, then written back (one RMW port).
// Reset: synchronous, active low; hint 1, count at the block total, then a fill pass over all
//   MAP_WORDS (4096) words marks every block used, during which no word is accepted.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [28:0] address, [58:29] region_bytes, [63:59] zero
    input  logic [63:0] s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [28:0] block_address, [30:29] status, [48:31] used_blocks, [55:49] zero
    output logic [55:0] m_axis_tdata
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SETUP    = 7'b0000010,
        S_SCAN     = 7'b0000100,
        S_ALLOC_WR = 7'b0001000,
        S_RGN_RD   = 7'b0010000,
        S_RGN_WR   = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    // Lowest clear bit of a map word.
    function automatic logic [4:0] first_zero(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            if (!v[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

    t_state             r_state,     n_state;
    logic [BLK_W-1:0]   r_b0,        n_b0;
    logic [N_W-1:0]     r_n,         n_n;
    logic               r_set,       n_set;
    logic [WORD_AW-1:0] r_w,         n_w;
    logic [WORD_AW-1:0] r_w_first,   n_w_first;
    logic [WORD_AW-1:0] r_w_last,    n_w_last;
    logic [4:0]         r_lo,        n_lo;
    logic [4:0]         r_hi,        n_hi;
    logic [WORD_AW-1:0] r_hint,      n_hint;
    logic [CNT_W-1:0]   r_used,      n_used;
    logic [WORD_AW:0]   r_issue_w,   n_issue_w;
    logic               r_pass,      n_pass;
    logic               r_pend,      n_pend;
    logic [WORD_AW-1:0] r_pend_w,    n_pend_w;
    logic [WORD_AW-1:0] r_found_w,   n_found_w;
    logic [4:0]         r_found_bit, n_found_bit;
    logic [31:0]        r_found_word, n_found_word;
    logic [ADDR_W-1:0]  r_res_addr,  n_res_addr;
    t_status            r_status,    n_status;
    logic               r_m_valid,   n_m_valid;
    logic [55:0]        r_m_data,    n_m_data;

    t_map_req           map_req;
    logic [31:0]        map_rd_data;
    logic               map_ready;

    logic [BLK_W-1:0]   in_blk;
    logic [WORD_AW-1:0] in_word;
    logic [WORD_AW-1:0] hint_eff;
    logic [BYTES_W:0]   bytes_sum;
    logic [END_W-1:0]   last_raw;
    logic [END_W-1:0]   last_c;
    logic [END_W-1:0]   sum_up;
    logic [31:0]        rgn_mask;
    logic [4:0]         mask_lo;
    logic [4:0]         mask_hi;
    logic               scan_more;
    logic               scan_hit;
    logic [WORD_AW+4:0] found_blk;

    bpfa_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (map_rd_data),
        .o_ready   (map_ready)
    );

    assign s_axis_tready = (r_state == S_IDLE) && map_ready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // decode of the incoming word
    assign in_blk    = BLK_W'(s_axis_tdata[ADDR_W-1:0] >> BLOCK_SHIFT);
    assign in_word   = WORD_AW'(in_blk >> 5);
    assign hint_eff  = (r_hint == '0) ? WORD_AW'(1) : r_hint;
    assign bytes_sum = (BYTES_W+1)'(s_axis_tdata[ADDR_W +: BYTES_W])
                     + (BYTES_W+1)'((1 << BLOCK_SHIFT) - 1);

    // last block of a region, clipped to the map
    assign last_raw = END_W'(r_b0) + END_W'(r_n) - END_W'(1);
    assign last_c   = (last_raw >= END_W'(TOTAL_BLOCKS)) ? END_W'(TOTAL_BLOCKS - 1) : last_raw;
    assign sum_up   = END_W'(r_used) + END_W'(r_n);

    // bits of the current region word: first word starts at lo, last word ends at hi
    assign mask_lo  = (r_w == r_w_first) ? r_lo : 5'd0;
    assign mask_hi  = (r_w == r_w_last) ? r_hi : 5'd31;
    assign rgn_mask = (FULL_WORD << mask_lo) & (FULL_WORD >> (5'd31 - mask_hi));

    // scan pass 0 runs hint..end, pass 1 runs 1..hint-1
    assign scan_more = !r_pass || (r_issue_w < {1'b0, r_hint});
    assign scan_hit  = r_pend && (map_rd_data != FULL_WORD);
    assign found_blk = {r_found_w, r_found_bit};

    always_comb begin
        n_state      = r_state;
        n_b0         = r_b0;
        n_n          = r_n;
        n_set        = r_set;
        n_w          = r_w;
        n_w_first    = r_w_first;
        n_w_last     = r_w_last;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_hint       = r_hint;
        n_used       = r_used;
        n_issue_w    = r_issue_w;
        n_pass       = r_pass;
        n_pend       = r_pend;
        n_pend_w     = r_pend_w;
        n_found_w    = r_found_w;
        n_found_bit  = r_found_bit;
        n_found_word = r_found_word;
        n_res_addr   = r_res_addr;
        n_status     = r_status;
        n_m_valid    = r_m_valid;
        n_m_data     = r_m_data;
        map_req      = '0;

        // drop the result once taken
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && map_ready) begin
                    n_b0       = in_blk;
                    n_status   = ST_OK;
                    n_res_addr = '0;
                    unique case (s_axis_tuser) inside
                        MD_ALLOC: begin
                            n_hint    = hint_eff;
                            n_issue_w = {1'b0, hint_eff};
                            n_pass    = 1'b0;
                            n_pend    = 1'b0;
                            n_state   = S_SCAN;
                        end
                        MD_FREE: begin
                            if (in_blk == '0) begin
                                n_status = ST_FREE0;
                                n_state  = S_DONE;
                            end else if (END_W'(in_blk) >= END_W'(TOTAL_BLOCKS)) begin
                                n_state = S_DONE;
                            end else begin
                                n_n   = N_W'(1);
                                n_set = 1'b0;
                                if (in_word < r_hint) begin
                                    n_hint = in_word;
                                end
                                n_state = S_SETUP;
                            end
                        end
                        MD_USED, MD_UNUSED: begin
                            n_n     = N_W'(bytes_sum >> BLOCK_SHIFT);
                            n_set   = (s_axis_tuser == MD_USED);
                            n_state = S_SETUP;
                        end
                        MD_RUN: begin
                            n_n     = N_W'(RUN_BLOCKS);
                            n_set   = 1'b0;
                            n_state = S_SETUP;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SETUP: begin
                // saturating count move, every block of the region counts
                if (r_set) begin
                    n_used = (sum_up >= END_W'(TOTAL_BLOCKS)) ? CNT_W'(TOTAL_BLOCKS)
                                                              : CNT_W'(sum_up);
                end else begin
                    n_used = (END_W'(r_n) >= END_W'(r_used)) ? '0 : r_used - CNT_W'(r_n);
                end
                n_w_first = WORD_AW'(r_b0 >> 5);
                n_w       = WORD_AW'(r_b0 >> 5);
                n_lo      = r_b0[4:0];
                n_w_last  = WORD_AW'(last_c >> 5);
                n_hi      = last_c[4:0];
                if (r_n == '0 || END_W'(r_b0) >= END_W'(TOTAL_BLOCKS)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RGN_RD;
                end
            end

            S_RGN_RD: begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = r_w;
                n_state         = S_RGN_WR;
            end

            S_RGN_WR: begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = r_w;
                map_req.wr_data = r_set ? (map_rd_data | rgn_mask) : (map_rd_data & ~rgn_mask);
                if (r_w == r_w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_w     = r_w + WORD_AW'(1);
                    n_state = S_RGN_RD;
                end
            end

            S_SCAN: begin
                if (scan_hit) begin
                    n_found_w    = r_pend_w;
                    n_found_word = map_rd_data;
                    n_found_bit  = first_zero(map_rd_data);
                    n_pend       = 1'b0;
                    n_state      = S_ALLOC_WR;
                end else if (scan_more) begin
                    // one read a cycle, the word arrives next cycle
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = WORD_AW'(r_issue_w);
                    n_pend          = 1'b1;
                    n_pend_w        = WORD_AW'(r_issue_w);
                    if (!r_pass && r_issue_w == (WORD_AW+1)'(MAP_WORDS - 1)) begin
                        n_issue_w = (WORD_AW+1)'(1);
                        n_pass    = 1'b1;
                    end else begin
                        n_issue_w = r_issue_w + (WORD_AW+1)'(1);
                    end
                end else begin
                    n_pend   = 1'b0;
                    n_status = ST_OOM;
                    n_state  = S_DONE;
                end
            end

            S_ALLOC_WR: begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = r_found_w;
                map_req.wr_data = r_found_word | (32'd1 << r_found_bit);
                n_hint          = r_found_w;
                n_used = (END_W'(r_used) + END_W'(1) >= END_W'(TOTAL_BLOCKS))
                       ? CNT_W'(TOTAL_BLOCKS) : r_used + CNT_W'(1);
                n_res_addr = ADDR_W'(found_blk) << BLOCK_SHIFT;
                n_state    = S_DONE;
            end

            S_DONE: begin
                // hold until the result register is free
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {7'd0, r_used, r_status, r_res_addr};
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hint    <= WORD_AW'(1);
            r_used    <= CNT_W'(TOTAL_BLOCKS);
            r_pass    <= 1'b0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_hint    <= n_hint;
            r_used    <= n_used;
            r_pass    <= n_pass;
            r_pend    <= n_pend;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0         <= n_b0;
        r_n          <= n_n;
        r_set        <= n_set;
        r_w          <= n_w;
        r_w_first    <= n_w_first;
        r_w_last     <= n_w_last;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_issue_w    <= n_issue_w;
        r_pend_w     <= n_pend_w;
        r_found_w    <= n_found_w;
        r_found_bit  <= n_found_bit;
        r_found_word <= n_found_word;
        r_res_addr   <= n_res_addr;
        r_status     <= n_status;
        r_m_data     <= n_m_data;
    end

endmodule
